[rtl/ihg_pkg.sv]
package ihg_pkg;

	localparam int DEF_GRID_ROWS  = 64;
	localparam int DEF_GRID_COLS  = 64;
	localparam int DEF_COST_WIDTH = 16;

	localparam int KIND_W   = 2;
	localparam int COORD_W  = 6;
	localparam int XY_W     = 2 * COORD_W;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_UP,
		ST_LAST,
		ST_DN_L,
		ST_DN_R,
		ST_FINAL
	} state_t;

endpackage

[rtl/ihg_req_if.sv]
interface ihg_req_if import ihg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [15:0]        in_cost;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;

	modport source (output valid, kind, in_cost, in_x, in_y, input ready);
	modport sink   (input valid, kind, in_cost, in_x, in_y, output ready);
endinterface

[rtl/ihg_rsp_if.sv]
interface ihg_rsp_if import ihg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COORD_W-1:0]  out_x;
	logic [COORD_W-1:0]  out_y;
	logic                found;

	modport source (output valid, status, out_x, out_y, found, input ready);
	modport sink   (input valid, status, out_x, out_y, found, output ready);
endinterface

[rtl/indexed_min_heap_grid_nodes.sv]
// channel | dir | payload
// req     | in  | kind, in_cost, in_x, in_y
// rsp     | out | status, out_x, out_y, found
//
// One request at a time. Queries, rejected requests and removes that leave the heap empty
// finish in ST_DECIDE. Insert climbs through ST_UP one level per pass and writes its entry
// in ST_FINAL; remove moves the last entry to the root in ST_LAST, then sifts down through
// ST_DN_L and ST_DN_R, reading the two children in turn (one heap memory read port).
// After reset the slot map is swept clear in ST_CLEAR, with req not ready.
// The result sits in an output register; a stalled rsp holds off the next request.
module indexed_min_heap_grid_nodes
	import ihg_pkg::*;
#(
	parameter int GRID_ROWS  = DEF_GRID_ROWS,
	parameter int GRID_COLS  = DEF_GRID_COLS,
	parameter int COST_WIDTH = DEF_COST_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ihg_req_if.sink    req,
	ihg_rsp_if.source  rsp
);

	localparam int CAP    = GRID_ROWS * GRID_COLS;
	localparam int SLOT_W = $clog2(CAP);
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int EW     = SLOT_W + 2;
	localparam int ENT_W  = COST_WIDTH + XY_W;

	typedef logic [COST_WIDTH-1:0] cost_t;
	typedef logic [XY_W-1:0]       xy_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	function automatic slot_t cell_of(xy_t xy);
		cell_of = SLOT_W'(SLOT_W'(xy[XY_W-1:COORD_W]) * SLOT_W'(GRID_COLS)
			+ SLOT_W'(xy[COORD_W-1:0]));
	endfunction

	logic [ENT_W-1:0] heap_mem [CAP];
	cnt_t             map_mem  [CAP];

	state_t state_q, state_d;

	logic [KIND_W-1:0] kind_q;
	cost_t             cost_q, cur_cost_q, lq_cost_q;
	xy_t               xy_q, cur_xy_q, lq_xy_q, res_xy_q;
	slot_t             pos_q, clr_q;
	cnt_t              cnt_q;

	logic                ovalid_q, found_q;
	logic [STATUS_W-1:0] status_q;

	logic [ENT_W-1:0] heap_rd;
	cnt_t             map_rd;

	logic             heap_we, map_we;
	slot_t            heap_wa, heap_ra, map_wa, map_ra;
	logic [ENT_W-1:0] heap_wd;
	cnt_t             map_wd;

	logic accept;
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !ovalid_q;

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		heap_rd <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd <= map_mem[map_ra];
	end

	// datapath terms
	cost_t            rd_cost, l_cost, pick_cost;
	xy_t              rd_xy, l_xy, pick_xy;
	logic             in_inside, q_inside, choose_r, dn_swap, up_swap, has_right;
	logic [EW-1:0]    left_c, right_c, nxt_left_c, cnt_e;
	slot_t            pick_idx, up_c, up2_c, par_cnt;

	assign rd_cost    = heap_rd[ENT_W-1:XY_W];
	assign rd_xy      = heap_rd[XY_W-1:0];
	assign in_inside  = (32'(req.in_x) < GRID_ROWS) && (32'(req.in_y) < GRID_COLS);
	assign q_inside   = (32'(xy_q[XY_W-1:COORD_W]) < GRID_ROWS)
		&& (32'(xy_q[COORD_W-1:0]) < GRID_COLS);
	assign cnt_e      = EW'(cnt_q);
	assign left_c     = {1'b0, pos_q, 1'b1};
	assign right_c    = left_c + EW'(1);
	assign has_right  = right_c < cnt_e;
	assign l_cost     = (state_q == ST_DN_R) ? lq_cost_q : rd_cost;
	assign l_xy       = (state_q == ST_DN_R) ? lq_xy_q : rd_xy;
	assign choose_r   = (state_q == ST_DN_R) && (lq_cost_q > rd_cost);
	assign pick_cost  = choose_r ? rd_cost : l_cost;
	assign pick_xy    = choose_r ? rd_xy : l_xy;
	assign pick_idx   = choose_r ? right_c[SLOT_W-1:0] : left_c[SLOT_W-1:0];
	assign nxt_left_c = {1'b0, pick_idx, 1'b1};
	assign dn_swap    = cur_cost_q > pick_cost;
	assign up_swap    = cur_cost_q < rd_cost;
	assign up_c       = (pos_q - SLOT_W'(1)) >> 1;
	assign up2_c      = (up_c - SLOT_W'(1)) >> 1;
	assign par_cnt    = SLOT_W'((cnt_q - CNT_W'(1)) >> 1);

	logic ins_ok;
	assign ins_ok = q_inside && (cnt_q != CNT_W'(CAP)) && (map_rd == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == SLOT_W'(CAP - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = ST_IDLE;
				if (kind_q == KIND_INSERT && ins_ok)
					state_d = (cnt_q == '0) ? ST_FINAL : ST_UP;
				else if (kind_q == KIND_REMOVE && cnt_q > CNT_W'(1))
					state_d = ST_LAST;
			end
			ST_UP: begin
				if (up_swap && up_c != '0) state_d = ST_UP;
				else state_d = ST_FINAL;
			end
			ST_LAST: state_d = (cnt_q > CNT_W'(1)) ? ST_DN_L : ST_FINAL;
			ST_DN_L, ST_DN_R: begin
				if (state_q == ST_DN_L && has_right) state_d = ST_DN_R;
				else if (dn_swap && nxt_left_c < cnt_e) state_d = ST_DN_L;
				else state_d = ST_FINAL;
			end
			ST_FINAL: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		heap_we = 1'b0;
		heap_wa = pos_q;
		heap_wd = {cur_cost_q, cur_xy_q};
		heap_ra = '0;
		map_we  = 1'b0;
		map_wa  = cell_of(cur_xy_q);
		map_wd  = CNT_W'(pos_q) + CNT_W'(1);
		map_ra  = in_inside ? cell_of({req.in_x, req.in_y}) : '0;
		case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
			end
			ST_DECIDE: begin
				if (kind_q == KIND_INSERT) begin
					heap_ra = par_cnt;
				end else if (kind_q == KIND_REMOVE && cnt_q != '0) begin
					map_we  = 1'b1;
					map_wa  = cell_of(rd_xy);
					map_wd  = '0;
					heap_ra = SLOT_W'(cnt_q - CNT_W'(1));
				end
			end
			ST_UP: begin
				heap_ra = up2_c;
				if (up_swap) begin
					heap_we = 1'b1;
					heap_wd = heap_rd;
					map_we  = 1'b1;
					map_wa  = cell_of(rd_xy);
				end
			end
			ST_LAST: heap_ra = SLOT_W'(1);
			ST_DN_L, ST_DN_R: begin
				if (state_q == ST_DN_L && has_right) begin
					heap_ra = right_c[SLOT_W-1:0];
				end else begin
					heap_ra = nxt_left_c[SLOT_W-1:0];
					if (dn_swap) begin
						heap_we = 1'b1;
						heap_wd = {pick_cost, pick_xy};
						map_we  = 1'b1;
						map_wa  = cell_of(pick_xy);
					end
				end
			end
			ST_FINAL: begin
				heap_we = 1'b1;
				map_we  = 1'b1;
			end
			default: ;
		endcase
	end

	// result of this cycle, if the request finishes here
	logic                fin;
	logic [STATUS_W-1:0] fin_status;
	logic                fin_found;
	always_comb begin
		fin        = (state_q == ST_FINAL);
		fin_status = STAT_OK;
		fin_found  = 1'b0;
		if (state_q == ST_DECIDE) begin
			case (kind_q)
				KIND_INSERT: begin
					fin = !ins_ok;
					if (!q_inside || cnt_q == CNT_W'(CAP)) fin_status = STAT_FULL;
					else fin_status = STAT_DUP;
				end
				KIND_REMOVE: begin
					fin = (cnt_q <= CNT_W'(1));
					if (cnt_q == '0) fin_status = STAT_EMPTY;
				end
				KIND_QUERY: begin
					fin       = 1'b1;
					fin_found = q_inside && (map_rd != '0);
				end
				default: fin = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SLOT_W'(1);
			if (state_q == ST_DECIDE) begin
				if (kind_q == KIND_INSERT && ins_ok) cnt_q <= cnt_q + CNT_W'(1);
				if (kind_q == KIND_REMOVE && cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
			end
			if (fin) ovalid_q <= 1'b1;
			else if (rsp.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			cost_q   <= COST_WIDTH'(req.in_cost);
			xy_q     <= {req.in_x, req.in_y};
			res_xy_q <= '0;
		end
		case (state_q)
			ST_DECIDE: begin
				pos_q      <= SLOT_W'(cnt_q);
				cur_cost_q <= cost_q;
				cur_xy_q   <= xy_q;
				if (kind_q == KIND_REMOVE && cnt_q != '0) res_xy_q <= rd_xy;
			end
			ST_UP: if (up_swap) pos_q <= up_c;
			ST_LAST: begin
				pos_q      <= '0;
				cur_cost_q <= rd_cost;
				cur_xy_q   <= rd_xy;
			end
			ST_DN_L, ST_DN_R: begin
				if (state_q == ST_DN_L) begin
					lq_cost_q <= rd_cost;
					lq_xy_q   <= rd_xy;
				end
				if (!(state_q == ST_DN_L && has_right) && dn_swap) pos_q <= pick_idx;
			end
			default: ;
		endcase
		if (fin) begin
			status_q <= fin_status;
			found_q  <= fin_found;
		end
	end

	assign rsp.valid  = ovalid_q;
	assign rsp.status = status_q;
	assign rsp.found  = found_q;
	assign rsp.out_x  = res_xy_q[XY_W-1:COORD_W];
	assign rsp.out_y  = res_xy_q[COORD_W-1:0];

endmodule

[rtl/ihg_checker.sv]
module ihg_checker
	import ihg_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [COORD_W-1:0]  out_x,
	input logic [COORD_W-1:0]  out_y,
	input logic                found
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while result pending");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (found || status != STAT_OK) |-> out_x == '0 && out_y == '0)
		else $error("coordinates on a non-remove result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found)
			&& $stable(out_x) && $stable(out_y))
		else $error("stalled result changed");

endmodule

bind indexed_min_heap_grid_nodes ihg_checker u_ihg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.out_x    (rsp.out_x),
	.out_y    (rsp.out_y),
	.found    (rsp.found)
);

[verif/tb.sv]
module tb;
	import ihg_pkg::*;

	localparam int ROWS = DEF_GRID_ROWS;
	localparam int COLS = DEF_GRID_COLS;
	localparam int CAP = ROWS * COLS;
	localparam int CYCLE_LIMIT = 900000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COORD_W-1:0]  ox;
		logic [COORD_W-1:0]  oy;
		logic                found;
	} heap_reply_t;

	logic clk;
	logic arst_n;
	ihg_req_if req ();
	ihg_rsp_if rsp ();

	indexed_min_heap_grid_nodes uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// predictor state
	logic [15:0] pq_cost [CAP];
	logic [11:0] pq_cell [CAP];
	int          pq_slot [CAP];
	int          pq_count;

	heap_reply_t replies_due [$];
	int errors;
	int n_sent;
	int n_checked;
	int n_removes;
	int n_specials;
	longint cycles;

	task automatic pq_put(input int s, input logic [15:0] c, input logic [11:0] e);
		pq_cost[s] = c;
		pq_cell[s] = e;
		pq_slot[e] = s + 1;
	endtask

	task automatic pq_swap(input int a, input int b);
		logic [15:0] c;
		logic [11:0] e;
		c = pq_cost[a];
		e = pq_cell[a];
		pq_put(a, pq_cost[b], pq_cell[b]);
		pq_put(b, c, e);
	endtask

	task automatic predict_heap(input logic [KIND_W-1:0] k, input logic [15:0] cost,
			input logic [5:0] x, input logic [5:0] y);
		heap_reply_t r;
		logic [11:0] cell_idx;
		logic [11:0] top;
		int p;
		int l;
		int pick;
		r = '0;
		cell_idx = {x, y};
		if (k == KIND_INSERT) begin
			if (pq_count >= CAP) begin
				r.status = STAT_FULL;
			end else if (pq_slot[cell_idx] != 0) begin
				r.status = STAT_DUP;
			end else begin
				r.status = STAT_OK;
				pq_put(pq_count, cost, cell_idx);
				p = pq_count;
				pq_count++;
				while (p > 0 && pq_cost[p] < pq_cost[(p - 1) / 2]) begin
					pq_swap(p, (p - 1) / 2);
					p = (p - 1) / 2;
				end
			end
		end else if (k == KIND_REMOVE) begin
			if (pq_count == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				top = pq_cell[0];
				r.ox = top[11:6];
				r.oy = top[5:0];
				pq_slot[top] = 0;
				pq_count--;
				if (pq_count > 0) begin
					pq_put(0, pq_cost[pq_count], pq_cell[pq_count]);
					p = 0;
					forever begin
						l = 2 * p + 1;
						if (l >= pq_count)
							break;
						pick = l;
						if (l + 1 < pq_count && pq_cost[l] > pq_cost[l + 1])
							pick = l + 1;
						if (pq_cost[p] > pq_cost[pick]) begin
							pq_swap(p, pick);
							p = pick;
						end else begin
							break;
						end
					end
				end
			end
		end else if (k == KIND_QUERY) begin
			r.found = (pq_slot[cell_idx] != 0);
		end
		if (r.status != STAT_OK)
			n_specials++;
		replies_due.push_back(r);
	endtask

	task automatic send_op(input logic [KIND_W-1:0] k, input logic [15:0] cost,
			input logic [5:0] x, input logic [5:0] y);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.in_cost <= cost;
		req.in_x <= x;
		req.in_y <= y;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		// transfer happened at this edge
		predict_heap(k, cost, x, y);
		n_sent++;
		if (k == KIND_REMOVE)
			n_removes++;
	endtask

	// receiver: stall draw per result
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			check_reply();
		end
	end

	task automatic check_reply();
		heap_reply_t e;
		if (replies_due.size() == 0) begin
			$display("%0t unexpected result status=%0d", $time, rsp.status);
			errors++;
			return;
		end
		e = replies_due.pop_front();
		n_checked++;
		if (rsp.status !== e.status) begin
			$display("%0t status exp %0d got %0d", $time, e.status, rsp.status);
			errors++;
		end
		if (rsp.out_x !== e.ox) begin
			$display("%0t out_x exp %0d got %0d", $time, e.ox, rsp.out_x);
			errors++;
		end
		if (rsp.out_y !== e.oy) begin
			$display("%0t out_y exp %0d got %0d", $time, e.oy, rsp.out_y);
			errors++;
		end
		if (rsp.found !== e.found) begin
			$display("%0t found exp %0d got %0d", $time, e.found, rsp.found);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		send_op(KIND_REMOVE, 16'h0, 6'd0, 6'd0);
		send_op(KIND_QUERY, 16'h0, 6'd63, 6'd63);
		send_op(KIND_INSERT, 16'hFFFF, 6'd63, 6'd63);
		send_op(KIND_INSERT, 16'h0000, 6'd0, 6'd0);
		send_op(KIND_INSERT, 16'h0000, 6'd1, 6'd2);
		send_op(KIND_INSERT, 16'h8000, 6'd42, 6'd21);
		send_op(KIND_INSERT, 16'h1234, 6'd0, 6'd0);
		send_op(KIND_INSERT, 16'h7FFF, 6'd21, 6'd42);
		send_op(KIND_QUERY, 16'hFFFF, 6'd63, 6'd63);
		send_op(KIND_QUERY, 16'h0, 6'd5, 6'd5);
		send_op(2'd3, 16'hFFFF, 6'd63, 6'd63);
		repeat (6)
			send_op(KIND_REMOVE, 16'h0, 6'd0, 6'd0);
		send_op(KIND_REMOVE, 16'hFFFF, 6'd63, 6'd63);
		send_op(KIND_QUERY, 16'h0, 6'd0, 6'd0);
	endtask

	// random mix of inserts, removes, queries and raw kinds, costs often narrowed to force ties
	task automatic test_random(input int n);
		int i;
		int mode;
		logic [15:0] c;
		logic [1:0] k;
		for (i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			c = 16'($urandom);
			if ($urandom_range(0, 1))
				c = c & 16'h000F;
			if (mode < 5)
				k = KIND_INSERT;
			else if (mode < 8)
				k = KIND_REMOVE;
			else if (mode < 9)
				k = KIND_QUERY;
			else
				k = 2'($urandom);
			send_op(k, c, $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 3)),
				6'($urandom));
		end
	endtask

	task automatic test_drain();
		while (pq_count > 0)
			send_op(KIND_REMOVE, 16'($urandom), 6'($urandom), 6'($urandom));
		send_op(KIND_REMOVE, 16'h0, 6'd0, 6'd0);
	endtask

	initial begin
		int k;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_removes = 0;
		n_specials = 0;
		cycles = 0;
		pq_count = 0;
		for (k = 0; k < CAP; k++)
			pq_slot[k] = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_INSERT;
		req.in_cost = '0;
		req.in_x = '0;
		req.in_y = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(700);
		test_drain();
		test_random(700);
		test_drain();
		req.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("tb: %0d requests, %0d results checked, %0d removes, %0d error statuses",
			n_sent, n_checked, n_removes, n_specials);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
